/* hdl/lmc_pkg.sv */
package lmc_pkg;

   typedef logic [1:0] csr_index_type;
   typedef logic [3:0] state_type;

   localparam csr_index_type CSR_BASE_DELAY = 2'd0;
   localparam csr_index_type CSR_MOD_DEPTH  = 2'd1;
   localparam csr_index_type CSR_LFO_PERIOD = 2'd2;
   localparam csr_index_type CSR_WET_AMOUNT = 2'd3;

   localparam state_type S_IDLE = 4'd0;
   localparam state_type S_DIV  = 4'd1;
   localparam state_type S_SINE = 4'd2;
   localparam state_type S_MOFF = 4'd3;
   localparam state_type S_ADDR = 4'd4;
   localparam state_type S_RDA  = 4'd5;
   localparam state_type S_RDB  = 4'd6;
   localparam state_type S_MA   = 4'd7;
   localparam state_type S_MB   = 4'd8;
   localparam state_type S_MX   = 4'd9;
   localparam state_type S_MW   = 4'd10;
   localparam state_type S_OUT  = 4'd11;

   localparam int COUNT_BITS  = 24;
   localparam int PHASE_BITS  = 16;
   localparam int DIV_STEPS   = COUNT_BITS + PHASE_BITS;
   localparam int DEPTH_BITS  = 20;
   localparam int WET_BITS    = 9;
   localparam int GAIN_BITS   = 18;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [16:0] WET_COEF    = 17'd39322;
   localparam logic [8:0]  WET_FULL    = 9'd256;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [PHASE_BITS-1:0] phase_type;

endpackage

/* hdl/lmc_phase_div.sv */
module lmc_phase_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lmc_pkg::count_type  count,
   input  lmc_pkg::count_type  period,
   output logic                done,
   output lmc_pkg::phase_type  phase
);
   import lmc_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   logic [DIV_STEPS-1:0]  num_ff, num_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] per_ff, per_in;
   phase_type             q_ff, q_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   assign trial = {rem_ff, num_ff[DIV_STEPS-1]};
   assign fits  = trial >= {1'b0, per_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      per_in  = per_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = {count, {PHASE_BITS{1'b0}}};
         rem_in  = '0;
         per_in  = period;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[DIV_STEPS-2:0], 1'b0};
         rem_in  = fits ? COUNT_BITS'(trial - {1'b0, per_ff}) : trial[COUNT_BITS-1:0];
         q_in    = {q_ff[PHASE_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      per_ff  <= per_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign phase = q_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("phase divider done without run");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("phase divider restarted while busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff < STEP_W'(DIV_STEPS)) else $error("phase divider overran");

endmodule

/* hdl/lfo_modulated_chorus.sv */
// from input transfer to result valid: the 40-step restoring divider for count*65536/period
// gives the lfo phase, then 10 sequencer steps on the shared multiplier produce the result
// the next sample is taken only once the block is back idle; a stalled result keeps it busy
// the divider and the sequencer do not overlap, so each sample runs through both in turn
// reset: synchronous, active high; control and csr registers return to defaults, ring reads zero until written
module lfo_modulated_chorus #(
   parameter int RING_DEPTH      = 4096,
   parameter int SAMPLE_BITS     = 24,
   parameter int SINE_TABLE_BITS = 10,
   parameter int FRAC_BITS       = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  lmc_pkg::csr_index_type        csr_index,
   input  logic [23:0]                   csr_data
);
   import lmc_pkg::*;

   localparam int AW     = $clog2(RING_DEPTH);
   localparam int SINE_N = 1 << SINE_TABLE_BITS;
   localparam int MA_W   = SAMPLE_BITS + FRAC_BITS + 1;
   localparam int P_W    = MA_W + GAIN_BITS;
   localparam int ACC_W  = P_W + 1;
   localparam int Y_W    = ACC_W - 16 - FRAC_BITS;
   localparam int CMP_W  = (AW + FRAC_BITS > DEPTH_BITS + 1) ? AW + FRAC_BITS : DEPTH_BITS + 1;
   localparam logic [CMP_W-1:0] DMAX =
      CMP_W'(((RING_DEPTH - 2) << FRAC_BITS) + (1 << FRAC_BITS) - 1);
   localparam logic signed [Y_W-1:0] SMAX = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Y_W-1:0] SMIN = Y_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   typedef logic [15:0] rom_type [0:SINE_N];

   function automatic rom_type build_rom();
      rom_type     r;
      logic [63:0] x, x2, t, s;
      for (int i = 0; i <= SINE_N; i++) begin
         x  = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - x2 / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         s  = (s + 64'd16384) >> 15;
         if (s > 64'd32767) s = 64'd32767;
         r[i] = s[15:0];
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];

   state_type                     state_ff, state_in;
   logic [DEPTH_BITS-1:0]         base_ff, depth_ff;
   count_type                     period_ff, count_ff, count_in;
   logic [WET_BITS-1:0]           wet_ff;
   logic [AW-1:0]                 wp_ff;
   logic                          wrapped_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff, a_ff, b_ff;
   logic [SAMPLE_BITS-1:0]        rd_ff;
   logic [14:0]                   sabs_ff;
   logic                          sneg_ff;
   logic [AW-1:0]                 ia_ff, ib_ff;
   logic                          va_ff, vb_ff;
   logic [FRAC_BITS-1:0]          frac_ff;
   logic signed [P_W-1:0]         p_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [MA_W-1:0]        chorus_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic                  accept, out_free;
   count_type             per_eff, count_next;
   logic                  div_done;
   phase_type             div_phase;
   logic [SINE_TABLE_BITS-1:0] sidx;
   logic [SINE_TABLE_BITS:0]   spos;
   logic [DEPTH_BITS-1:0] depth_use, off;
   logic [CMP_W-1:0]      d_raw, d_cl;
   logic [AW-1:0]         di, ia;
   logic [WET_BITS-1:0]   w_use;
   logic [GAIN_BITS-1:0]  dry16, wet16;
   logic [25:0]           wet_prod;
   logic signed [MA_W-1:0]      mul_a;
   logic signed [GAIN_BITS-1:0] mul_b;
   logic signed [P_W-1:0]       prod;
   logic signed [ACC_W-1:0]     acc_sum;
   logic signed [Y_W-1:0]       y;
   logic signed [Y_W-1:0]       y_sat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign per_eff    = (period_ff == '0) ? COUNT_BITS'(1) : period_ff;
   assign count_next = count_ff + 1'b1;

   lmc_phase_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .count  (count_ff),
      .period (per_eff),
      .done   (div_done),
      .phase  (div_phase)
   );

   assign sidx = div_phase[13 -: SINE_TABLE_BITS];
   assign spos = div_phase[14] ? (SINE_TABLE_BITS + 1)'(SINE_N) - {1'b0, sidx} : {1'b0, sidx};

   assign depth_use = (depth_ff < base_ff) ? depth_ff : base_ff;
   assign off       = p_ff[15 +: DEPTH_BITS];
   assign d_raw     = sneg_ff ? CMP_W'(base_ff) - CMP_W'(off) : CMP_W'(base_ff) + CMP_W'(off);
   assign d_cl      = (d_raw > DMAX) ? DMAX : d_raw;
   assign di        = d_cl[FRAC_BITS +: AW];
   assign ia        = wp_ff - di;

   assign w_use    = (wet_ff > WET_FULL) ? WET_FULL : wet_ff;
   assign dry16    = GAIN_BITS'({10'd512 - {1'b0, w_use}, 7'd0});
   assign wet_prod = 26'(WET_COEF) * 26'(w_use) + 26'd128;
   assign wet16    = GAIN_BITS'(wet_prod >> 8);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MOFF: begin
            mul_a = MA_W'(depth_use);
            mul_b = GAIN_BITS'(sabs_ff);
         end
         S_MA: begin
            mul_a = MA_W'(a_ff);
            mul_b = GAIN_BITS'((FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, frac_ff});
         end
         S_MB: begin
            mul_a = MA_W'(b_ff);
            mul_b = GAIN_BITS'(frac_ff);
         end
         S_MX: begin
            mul_a = MA_W'(x_ff);
            mul_b = dry16;
         end
         S_MW: begin
            mul_a = chorus_ff;
            mul_b = wet16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod    = P_W'(mul_a) * P_W'(mul_b);
   assign acc_sum = acc_ff + ACC_W'(p_ff) + ACC_W'(64'sd1 <<< (15 + FRAC_BITS));
   assign y       = Y_W'(acc_sum >>> (16 + FRAC_BITS));
   assign y_sat   = (y > SMAX) ? SMAX : ((y < SMIN) ? SMIN : y);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DIV;
               count_in = (count_next >= per_eff) ? '0 : count_next;
            end
         end
         S_DIV:  if (div_done) state_in = S_SINE;
         S_SINE: state_in = S_MOFF;
         S_MOFF: state_in = S_ADDR;
         S_ADDR: state_in = S_RDA;
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_MA;
         S_MA:   state_in = S_MB;
         S_MB:   state_in = S_MX;
         S_MX:   state_in = S_MW;
         S_MW:   state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) ring[wp_ff] <= req_sample_in;
      case (state_ff)
         S_RDA:   rd_ff <= ring[ia_ff];
         S_RDB:   rd_ff <= ring[ib_ff];
         default: rd_ff <= rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) x_ff <= req_sample_in;
      if (state_ff == S_SINE) begin
         sabs_ff <= SINE_ROM[spos][14:0];
         sneg_ff <= div_phase[15];
      end
      if (state_ff == S_ADDR) begin
         ia_ff   <= ia;
         ib_ff   <= ia - 1'b1;
         va_ff   <= wrapped_ff || (ia <= wp_ff);
         vb_ff   <= wrapped_ff || ((ia - 1'b1) <= wp_ff);
         frac_ff <= d_cl[FRAC_BITS-1:0];
      end
      if (state_ff == S_RDB) a_ff <= va_ff ? rd_ff : '0;
      if (state_ff == S_MA)  b_ff <= vb_ff ? rd_ff : '0;
      if (state_ff == S_MB)  acc_ff <= ACC_W'(p_ff);
      if (state_ff == S_MX)  chorus_ff <= MA_W'(acc_ff + ACC_W'(p_ff));
      if (state_ff == S_MW)  acc_ff <= ACC_W'(p_ff) <<< FRAC_BITS;
      if (state_ff == S_MOFF || state_ff == S_MA || state_ff == S_MB ||
          state_ff == S_MX || state_ff == S_MW) p_ff <= prod;
      if (state_ff == S_OUT && out_free) out_ff <= SAMPLE_BITS'(y_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= DEPTH_BITS'(307200);
         depth_ff     <= DEPTH_BITS'(12288);
         period_ff    <= COUNT_BITS'(60000);
         wet_ff       <= WET_FULL;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == S_OUT && out_free) begin
            wp_ff        <= wp_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
            if (wp_ff == AW'(RING_DEPTH - 1)) wrapped_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_DELAY: base_ff   <= csr_data[DEPTH_BITS-1:0];
               CSR_MOD_DEPTH:  depth_ff  <= csr_data[DEPTH_BITS-1:0];
               CSR_LFO_PERIOD: period_ff <= csr_data[COUNT_BITS-1:0];
               CSR_WET_AMOUNT: wet_ff    <= csr_data[WET_BITS-1:0];
               default:        base_ff   <= base_ff;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DIV) else $error("input transfer did not start divider");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT) else $error("result raised outside output step");
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider finished outside wait step");
   a_wp_once: assert property (@(posedge clock) disable iff (reset)
      wp_ff != $past(wp_ff) |-> $past(state_ff) == S_OUT) else $error("write pointer moved twice");

endmodule

/* tb/lfo_modulated_chorus_checker.sv */
`timescale 1ns / 100ps

module lfo_modulated_chorus_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [23:0]   req_sample_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [23:0]   rsp_sample_out,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  lmc_pkg::csr_index_type csr_index,
   input  logic [23:0]          csr_data,
   output int                   failures,
   output int                   pending
);
   import lmc_pkg::*;

   localparam int RING = 4096;

   logic signed [23:0] echo_ring [RING];
   logic [11:0]        wr_ptr;
   logic [23:0]        lfo_cnt;
   logic [19:0]        base_dly;
   logic [19:0]        depth_q;
   logic [23:0]        period_q;
   logic [8:0]         wet_q;
   logic signed [15:0] quarter_rom [1025];
   logic signed [23:0] expected_out [$];

   function automatic logic signed [15:0] rom_entry(input int i);
      longint unsigned x, x2, t, s;
      x  = (longint'(i) * 64'd1686629713) >> 10;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return 16'(s);
   endfunction

   function automatic logic signed [23:0] chorus_sample(input logic signed [23:0] x_in);
      longint unsigned per, ph, d, off, dep, mag, frac, w;
      logic [1:0]  quad;
      int          idx, pos, di;
      logic [11:0] ia, ib;
      longint      sv, a, b, mix, dry, wet, acc, y;
      echo_ring[wr_ptr] = x_in;
      per = (period_q == 0) ? 1 : period_q;
      ph  = ((longint'(lfo_cnt) << 16) / per) & 16'hFFFF;
      lfo_cnt = ((longint'(lfo_cnt) + 1) >= per) ? 24'd0 : lfo_cnt + 24'd1;
      quad = ph[15:14];
      idx  = int'(ph[13:4]);
      pos  = quad[0] ? 1024 - idx : idx;
      sv   = quarter_rom[pos];
      if (quad[1]) sv = -sv;
      dep = (depth_q < base_dly) ? depth_q : base_dly;
      mag = (sv < 0) ? -sv : sv;
      off = (dep * mag) >> 15;
      d   = (sv < 0) ? base_dly - off : base_dly + off;
      if (d > ((4094 << 8) | 255)) d = (4094 << 8) | 255;
      di   = int'(d >> 8);
      frac = d & 255;
      ia = 12'(wr_ptr - di);
      ib = 12'(wr_ptr - di - 1);
      a  = echo_ring[ia];
      b  = echo_ring[ib];
      mix = a * longint'(256 - frac) + b * longint'(frac);
      w   = (wet_q > 256) ? 256 : wet_q;
      dry = longint'(512 - w) * 128;
      wet = longint'((39322 * w + 128) >> 8);
      acc = longint'(x_in) * dry * 256 + mix * wet + (longint'(1) << 23);
      y   = acc >>> 24;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      wr_ptr = wr_ptr + 12'd1;
      return 24'(y);
   endfunction

   initial begin
      for (int i = 0; i <= 1024; i++) quarter_rom[i] = rom_entry(i);
      failures = 0;
   end

   assign pending = expected_out.size();

   always @(posedge clock) begin
      logic signed [23:0] want;
      if (reset) begin
         for (int i = 0; i < RING; i++) echo_ring[i] = '0;
         wr_ptr   = '0;
         lfo_cnt  = '0;
         base_dly = 20'd307200;
         depth_q  = 20'd12288;
         period_q = 24'd60000;
         wet_q    = 9'd256;
         expected_out.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_DELAY: base_dly = csr_data[19:0];
               CSR_MOD_DEPTH:  depth_q  = csr_data[19:0];
               CSR_LFO_PERIOD: period_q = csr_data;
               CSR_WET_AMOUNT: wet_q    = csr_data[8:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               $display("%0t: sample_out expected none, got %0d", $time, rsp_sample_out);
               failures++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_sample_out !== want) begin
                  $display("%0t: sample_out expected %0d, got %0d",
                           $time, want, rsp_sample_out);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) expected_out.push_back(chorus_sample(req_sample_in));
      end
   end

endmodule

/* tb/tb_lfo_modulated_chorus.sv */
`timescale 1ns / 100ps

module tb_lfo_modulated_chorus;
   import lmc_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [23:0] req_sample_in;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [23:0] rsp_sample_out;
   logic               csr_valid;
   logic               csr_ready;
   csr_index_type      csr_index;
   logic [23:0]        csr_data;
   int                 failures;
   int                 pending;
   bit                 quiet;
   bit                 hold_request;
   bit                 hold_done;

   lfo_modulated_chorus u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   lfo_modulated_chorus_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= 1000000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver side, with one long hold-off to back the block up
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_sample(input logic signed [23:0] value);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input csr_index_type index, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain every expected transfer, then cover the block's latency
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_setup();
      logic [23:0] junk;
      junk = 24'($urandom);
      if ($urandom_range(0, 1))
         write_reg(CSR_BASE_DELAY, {junk[23:20], 20'($urandom_range(0, 4095 * 256))});
      else
         write_reg(CSR_BASE_DELAY, {junk[23:20], 20'($urandom)});
      write_reg(CSR_MOD_DEPTH, {junk[19:16], 20'($urandom)});
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_LFO_PERIOD, 24'($urandom));
      else
         write_reg(CSR_LFO_PERIOD, 24'($urandom_range(0, 300)));
      write_reg(CSR_WET_AMOUNT, {junk[14:0], 9'($urandom)});
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_BASE_DELAY;
      csr_data      = '0;
      quiet         = 1'b0;
      hold_request  = 1'b0;
      hold_done     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sample extremes at reset settings
      send_sample(24'sh7FFFFF);
      send_sample(-24'sh800000);
      send_sample(24'sd0);
      send_sample(-24'sd1);
      send_sample(24'sh555555);
      send_sample(24'shAAAAAA);
      settle();

      // zero delay, depth above base, zero period, wet above full
      write_reg(CSR_BASE_DELAY, 24'd0);
      write_reg(CSR_MOD_DEPTH, 24'hFFFFFF);
      write_reg(CSR_LFO_PERIOD, 24'd0);
      write_reg(CSR_WET_AMOUNT, 24'hFFFFFF);
      send_sample(24'sh7FFFFF);
      send_sample(-24'sh800000);
      send_sample(24'sd12345);
      settle();

      // long delay saturation, dry only
      write_reg(CSR_BASE_DELAY, 24'h0FFFFF);
      write_reg(CSR_MOD_DEPTH, 24'd0);
      write_reg(CSR_LFO_PERIOD, 24'd1000);
      write_reg(CSR_WET_AMOUNT, 24'd0);
      for (int i = 0; i < 8; i++) send_sample(24'($urandom));
      settle();

      // period lowered below the running count
      write_reg(CSR_BASE_DELAY, 24'd1000);
      write_reg(CSR_MOD_DEPTH, 24'd800);
      write_reg(CSR_LFO_PERIOD, 24'd4);
      write_reg(CSR_WET_AMOUNT, 24'd256);
      for (int i = 0; i < 6; i++) send_sample(24'($urandom));
      settle();

      for (int p = 0; p < 8; p++) begin
         random_setup();
         if (p == 3) hold_request = 1'b1;
         if (p == 7) quiet = 1'b1;
         for (int i = 0; i < 128; i++) send_sample(24'($urandom));
         settle();
      end

      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/lmc_pkg.sv
hdl/lmc_phase_div.sv
hdl/lfo_modulated_chorus.sv
tb/lfo_modulated_chorus_checker.sv
tb/tb_lfo_modulated_chorus.sv
